### rtl/core/dns_response_a_record_parser_top_defines.svh
// Assertion macros for the DNS response A-record parser.
// Used by dns_response_a_record_parser_top; define SYNTH to compile them out.
`ifndef DNS_RESPONSE_A_RECORD_PARSER_TOP_DEFINES_SVH
`define DNS_RESPONSE_A_RECORD_PARSER_TOP_DEFINES_SVH

`ifndef SYNTH

`define DNSARP_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("dns parser: property failed");

`define DNSARP_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("dns parser: forbidden condition seen");

`else

`define DNSARP_ASSERT(lbl, clk, rst, prop)

`define DNSARP_ASSERT_NEVER(lbl, clk, rst, expr)

`endif

`endif

### rtl/core/dnsarp_pkg.sv
// Shared types and constants for the DNS response A-record parser.
// No dependencies.
`timescale 1ns / 1ps

package dnsarp_pkg;

   localparam int MAX_PACKET_DEFAULT = 512;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_SHORT     = 3'd1;
   localparam logic [2:0] ST_ID        = 3'd2;
   localparam logic [2:0] ST_NOTRESP   = 3'd3;
   localparam logic [2:0] ST_RCODE     = 3'd4;
   localparam logic [2:0] ST_MALFORMED = 3'd5;
   localparam logic [2:0] ST_NOA       = 3'd6;
   localparam logic [2:0] ST_UNDECIDED = 3'd7;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] address;
   } rsp_type;

endpackage

### rtl/core/dnsarp_parser.sv
// Byte-at-a-time DNS response walker: header checks, question skip, answer scan.
// Depends on dnsarp_pkg.
`timescale 1ns / 1ps

module dnsarp_parser #(
   parameter int MAX_PACKET = dnsarp_pkg::MAX_PACKET_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [15:0]          txn_id,
   input  logic                 step_valid,
   input  dnsarp_pkg::req_type  step_word,
   output dnsarp_pkg::rsp_type  result
);
   import dnsarp_pkg::*;

   localparam int OFF_W = $clog2(MAX_PACKET + 1);
   localparam logic [OFF_W-1:0] MAX_OFF = OFF_W'(MAX_PACKET);
   localparam logic [OFF_W-1:0] HDR_LEN = OFF_W'(12);

   typedef enum logic [2:0] {
      PH_HEADER, PH_QNAME, PH_QFIXED, PH_ANAME, PH_AFIXED, PH_RDATA, PH_DONE
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [OFF_W-1:0] offset_ff, offset_in;
   logic [3:0]       field_ff, field_in;
   logic [7:0]       header_ff, header_in;
   logic [15:0]      questions_ff, questions_in;
   logic [15:0]      answers_ff, answers_in;
   logic [15:0]      skip_ff, skip_in;
   logic [15:0]      rtype_ff, rtype_in;
   logic [31:0]      addr_ff, addr_in;
   logic [2:0]       outcome_ff, outcome_in;

   logic [7:0]  b;
   logic [15:0] word16;
   logic [15:0] q_val;
   logic [15:0] a_dec;
   logic [15:0] rd_len;
   logic        start_q;
   logic        rec_done;
   logic        name_done;
   logic        fin;
   logic [2:0]  fin_code;
   logic [2:0]  status;

   always_comb begin
      b            = step_word.data_byte;
      word16       = {header_ff, b};
      rd_len       = skip_ff | {8'h00, b};
      a_dec        = answers_ff - 16'd1;
      q_val        = questions_ff;
      start_q      = 1'b0;
      rec_done     = 1'b0;
      name_done    = 1'b0;
      fin          = 1'b0;
      fin_code     = ST_UNDECIDED;
      phase_in     = phase_ff;
      offset_in    = offset_ff;
      field_in     = field_ff;
      header_in    = header_ff;
      questions_in = questions_ff;
      answers_in   = answers_ff;
      skip_in      = skip_ff;
      rtype_in     = rtype_ff;
      addr_in      = addr_ff;
      outcome_in   = outcome_ff;
      status       = ST_UNDECIDED;

      if (step_valid && offset_ff < MAX_OFF) begin
         offset_in = offset_ff + OFF_W'(1);
         case (phase_ff)
            PH_HEADER: begin
               header_in = b;
               field_in  = field_ff + 4'd1;
               if (field_ff == 4'd1) begin
                  if (word16 != txn_id) begin
                     fin      = 1'b1;
                     fin_code = ST_ID;
                  end
               end else if (field_ff == 4'd3) begin
                  if (!word16[15]) begin
                     fin      = 1'b1;
                     fin_code = ST_NOTRESP;
                  end else if (word16[3:0] != 4'h0) begin
                     fin      = 1'b1;
                     fin_code = ST_RCODE;
                  end
               end else if (field_ff == 4'd5) begin
                  questions_in = word16;
               end else if (field_ff == 4'd7) begin
                  answers_in = word16;
               end else if (field_ff == 4'd11) begin
                  start_q = 1'b1;
               end
            end
            PH_QNAME, PH_ANAME: begin
               if (field_ff == 4'd1) begin
                  name_done = 1'b1;           // byte after a compression pointer
               end else if (skip_ff != 16'd0) begin
                  skip_in = skip_ff - 16'd1;
               end else if (b == 8'h00) begin
                  name_done = 1'b1;
               end else if (b[7:6] == 2'b11) begin
                  field_in = 4'd1;
               end else if (b > 8'd63) begin
                  fin      = 1'b1;
                  fin_code = ST_MALFORMED;
               end else begin
                  skip_in = {8'h00, b};
               end
            end
            PH_QFIXED: begin
               if (field_ff == 4'd3) begin
                  q_val        = questions_ff - 16'd1;
                  questions_in = q_val;
                  start_q      = 1'b1;
               end else begin
                  field_in = field_ff + 4'd1;
               end
            end
            PH_AFIXED: begin
               if (field_ff == 4'd0) begin
                  rtype_in = {b, 8'h00};
               end else if (field_ff == 4'd1) begin
                  rtype_in = rtype_ff | {8'h00, b};
               end else if (field_ff == 4'd8) begin
                  skip_in = {b, 8'h00};
               end
               if (field_ff == 4'd9) begin
                  skip_in = rd_len;
                  addr_in = 32'h0;
                  if (rd_len == 16'd0) begin
                     rec_done = 1'b1;
                  end else begin
                     phase_in = PH_RDATA;
                     // in rdata, field 0 flags a 4-byte payload
                     field_in = (rd_len == 16'd4) ? 4'd0 : 4'd1;
                  end
               end else begin
                  field_in = field_ff + 4'd1;
               end
            end
            PH_RDATA: begin
               addr_in = {addr_ff[23:0], b};
               skip_in = skip_ff - 16'd1;
               if (skip_ff == 16'd1) begin
                  if (rtype_ff == 16'd1 && field_ff == 4'd0) begin
                     fin      = 1'b1;
                     fin_code = ST_OK;
                  end else begin
                     rec_done = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase

         if (name_done) begin
            phase_in = (phase_ff == PH_QNAME) ? PH_QFIXED : PH_AFIXED;
            field_in = 4'd0;
            skip_in  = 16'd0;
         end
         if (start_q) begin
            if (q_val != 16'd0) begin
               phase_in = PH_QNAME;
               field_in = 4'd0;
               skip_in  = 16'd0;
            end else if (answers_ff == 16'd0) begin
               fin      = 1'b1;
               fin_code = ST_NOA;
            end else begin
               phase_in = PH_ANAME;
               field_in = 4'd0;
               skip_in  = 16'd0;
            end
         end
         if (rec_done) begin
            answers_in = a_dec;
            if (a_dec == 16'd0) begin
               fin      = 1'b1;
               fin_code = ST_NOA;
            end else begin
               phase_in = PH_ANAME;
               field_in = 4'd0;
               skip_in  = 16'd0;
            end
         end
         if (fin) begin
            outcome_in = fin_code;
            phase_in   = PH_DONE;
         end
      end

      if (offset_in < HDR_LEN) begin
         status = ST_SHORT;
      end else if (outcome_in != ST_UNDECIDED) begin
         status = outcome_in;
      end else begin
         status = ST_MALFORMED;
      end
      result.status  = status;
      result.address = (status == ST_OK) ? addr_in : 32'h0;

      // the last word closes the packet: back to the reset state
      if (step_valid && step_word.last_byte) begin
         phase_in     = PH_HEADER;
         offset_in    = '0;
         field_in     = 4'd0;
         header_in    = 8'h00;
         questions_in = 16'd0;
         answers_in   = 16'd0;
         skip_in      = 16'd0;
         rtype_in     = 16'd0;
         addr_in      = 32'h0;
         outcome_in   = ST_UNDECIDED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         offset_ff    <= '0;
         field_ff     <= 4'd0;
         header_ff    <= 8'h00;
         questions_ff <= 16'd0;
         answers_ff   <= 16'd0;
         skip_ff      <= 16'd0;
         rtype_ff     <= 16'd0;
         addr_ff      <= 32'h0;
         outcome_ff   <= ST_UNDECIDED;
      end else begin
         phase_ff     <= phase_in;
         offset_ff    <= offset_in;
         field_ff     <= field_in;
         header_ff    <= header_in;
         questions_ff <= questions_in;
         answers_ff   <= answers_in;
         skip_ff      <= skip_in;
         rtype_ff     <= rtype_in;
         addr_ff      <= addr_in;
         outcome_ff   <= outcome_in;
      end
   end

endmodule

### rtl/core/dns_response_a_record_parser_top.sv
// DNS response parser that extracts the first IPv4 A record of a packet. Bytes
// enter one word per cycle, sustained, with no gaps needed between packets;
// each word waits in the input register while the parser updates its
// state in a single pass, and the status/address word for a packet is loaded
// into the result register at the edge where its last byte leaves the input
// register, and rsp_valid rises at that same edge. The
// input side stalls only when a finished result is still waiting and the next
// last byte needs the result register. Bytes beyond MAX_PACKET are ignored
// apart from their last-byte mark. csr_wdata sets the expected transaction ID;
// write it only while no packet is in flight. Status codes: 0 ok, 1 short,
// 2 ID mismatch, 3 not a response, 4 RCODE error, 5 malformed, 6 no A record.
// Depends on dnsarp_pkg, dnsarp_parser and the assertion macro header.
`timescale 1ns / 1ps
`include "dns_response_a_record_parser_top_defines.svh"

module dns_response_a_record_parser_top #(
   parameter int MAX_PACKET = dnsarp_pkg::MAX_PACKET_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [15:0]          csr_wdata,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  dnsarp_pkg::req_type  req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output dnsarp_pkg::rsp_type  rsp_data
);
   import dnsarp_pkg::*;

   logic [15:0] txn_id_ff;
   logic        in_valid_ff, in_valid_in;
   req_type     in_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff;
   rsp_type     parse_result;
   logic        advance;
   logic        emit;

   // a non-last word never needs the result register
   assign advance   = in_valid_ff && (!in_ff.last_byte || !rsp_valid_ff || rsp_ready);
   assign emit      = advance && in_ff.last_byte;
   assign req_ready = !in_valid_ff || advance;

   assign in_valid_in  = req_ready ? req_valid : in_valid_ff;
   assign rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);

   dnsarp_parser #(
      .MAX_PACKET(MAX_PACKET)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .txn_id     (txn_id_ff),
      .step_valid (advance),
      .step_word  (in_ff),
      .result     (parse_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         txn_id_ff    <= 16'h0000;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            txn_id_ff <= csr_wdata;
         end
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
      if (emit) begin
         rsp_ff <= parse_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `DNSARP_ASSERT(a_stall_holds_word, clock, reset,
                  in_valid_ff && !advance |=> in_valid_ff && $stable(in_ff))
   `DNSARP_ASSERT(a_stall_cause, clock, reset,
                  !req_ready |-> in_valid_ff && in_ff.last_byte && rsp_valid_ff && !rsp_ready)
   `DNSARP_ASSERT(a_addr_zero_on_fail, clock, reset,
                  rsp_valid_ff && rsp_ff.status != ST_OK |-> rsp_ff.address == 32'h0)
   `DNSARP_ASSERT_NEVER(a_no_undecided, clock, reset,
                        rsp_valid_ff && rsp_ff.status == ST_UNDECIDED)

endmodule
